// File: design/gist_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gist_pkg: shared types and constants of the gyro inactivity sleep timer
// Field widths, register reset values, reciprocal constants for the divisions
// by one thousand, and the configuration register indexes.
// ----------------------------------------------------------------------------
package gist_pkg;

  // Default width of the millisecond time base.
  localparam int TIME_WIDTH_DEF = 48;

  // Sample field widths.
  localparam int WHOLE_W = 7;
  localparam int MICRO_W = 21;
  // Signed axis rate in micro-rad/s and its magnitude.
  localparam int RATE_W  = 27;
  localparam int MAG_W   = 26;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int SUMSQ_W = 54;
  localparam int PEAK_W  = 18;
  localparam int SECS_W  = 16;

  // Configuration register widths and reset values.
  localparam int THR_W      = 54;
  localparam int MS_CFG_W   = 26;
  localparam int CFG_DATA_W = 54;
  localparam logic [THR_W-1:0]    THR_RST      = 54'd10000000000;
  localparam logic [MS_CFG_W-1:0] TIMEOUT_RST  = 26'd30000;
  localparam logic [MS_CFG_W-1:0] INTERVAL_RST = 26'd5000;

  // One rad/s in micro-rad/s.
  localparam logic signed [RATE_W-1:0] MICRO_PER_UNIT = 27'sd1000000;

  // Idle time at and above which the seconds count saturates.
  localparam logic [31:0]        IDLE_SAT_MS = 32'd65536000;
  localparam logic [SECS_W-1:0]  IDLE_SAT_S  = 16'd65535;

  // x / 1000 = (x * ceil(2^k / 1000)) >> k, exact over the ranges used here.
  localparam int MSUM_W       = 22;
  localparam int RECIP_MS_SH  = 32;
  localparam logic [22:0] RECIP_MS = 23'd4294968;
  localparam int RECIP_S_SH   = 36;
  localparam logic [26:0] RECIP_S  = 27'd68719477;

  typedef enum logic [1:0] {
    CFG_MOTION_THR      = 2'd0,
    CFG_IDLE_TIMEOUT    = 2'd1,
    CFG_STATUS_INTERVAL = 2'd2
  } gist_cfg_idx_t;

endpackage
`default_nettype wire

// File: design/gist_axis_mag.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gist_axis_mag: magnitude of one gyro axis
// Joins the whole rad/s and micro-rad/s parts into one signed rate in
// micro-rad/s and returns its magnitude together with the part magnitudes.
// ----------------------------------------------------------------------------
module gist_axis_mag (
  input  wire logic signed [gist_pkg::WHOLE_W-1:0] whole,
  input  wire logic signed [gist_pkg::MICRO_W-1:0] micro,
  output logic [gist_pkg::MAG_W-1:0]               rate_mag,
  output logic [gist_pkg::WHOLE_W-1:0]             whole_mag,
  output logic [gist_pkg::MICRO_W-1:0]             micro_mag
);

  logic signed [gist_pkg::RATE_W-1:0] rate;
  logic signed [gist_pkg::RATE_W-1:0] rate_neg;
  logic signed [gist_pkg::WHOLE_W:0]  whole_ext;
  logic signed [gist_pkg::MICRO_W:0]  micro_ext;

  always_comb begin
    // The parts may disagree in sign; they are simply added.
    rate      = gist_pkg::RATE_W'(whole) * gist_pkg::MICRO_PER_UNIT
              + gist_pkg::RATE_W'(micro);
    rate_neg  = -rate;
    rate_mag  = rate[gist_pkg::RATE_W-1] ? rate_neg[gist_pkg::MAG_W-1:0]
                                         : rate[gist_pkg::MAG_W-1:0];
    whole_ext = (gist_pkg::WHOLE_W+1)'(whole);
    micro_ext = (gist_pkg::MICRO_W+1)'(micro);
    whole_mag = whole[gist_pkg::WHOLE_W-1] ? gist_pkg::WHOLE_W'(-whole_ext)
                                           : gist_pkg::WHOLE_W'(whole_ext);
    micro_mag = micro[gist_pkg::MICRO_W-1] ? gist_pkg::MICRO_W'(-micro_ext)
                                           : gist_pkg::MICRO_W'(micro_ext);
  end

endmodule
`default_nettype wire

// File: design/gyro_inactivity_sleep_timer.sv
`default_nettype none
// Throughput: one sample transfer per clock cycle, sustained, with no stall
//   while the result side keeps taking results.
// Pipeline: six register stages, from the input register (stage 0) to the
//   result register (stage 5).
// Reset (rst_n low, synchronous) empties the pipeline, restores the default
//   configuration and clears the motion time, report time and peak to zero.
// ----------------------------------------------------------------------------
// gyro_inactivity_sleep_timer: motion inactivity timeout detector
// Detects gyro motion against a squared threshold, tracks the peak L1 rate,
// issues periodic status reports and requests sleep after an idle timeout.
// ----------------------------------------------------------------------------
module gyro_inactivity_sleep_timer #(
  parameter int TIME_WIDTH = gist_pkg::TIME_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // Sample channel.
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [gist_pkg::WHOLE_W-1:0] in_rate_x_whole,
  input  wire logic signed [gist_pkg::MICRO_W-1:0] in_rate_x_micro,
  input  wire logic signed [gist_pkg::WHOLE_W-1:0] in_rate_y_whole,
  input  wire logic signed [gist_pkg::MICRO_W-1:0] in_rate_y_micro,
  input  wire logic signed [gist_pkg::WHOLE_W-1:0] in_rate_z_whole,
  input  wire logic signed [gist_pkg::MICRO_W-1:0] in_rate_z_micro,
  input  wire logic [TIME_WIDTH-1:0]               in_now_ms,
  // Result channel.
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic                                     out_sleep_request,
  output logic                                     out_status_valid,
  output logic [gist_pkg::SECS_W-1:0]              out_idle_seconds,
  output logic [gist_pkg::PEAK_W-1:0]              out_peak_rate_mrad,
  // Configuration write port.
  input  wire logic                                cfg_we,
  input  wire logic [1:0]                          cfg_index,
  input  wire logic [gist_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int NUM_STG = 6;
  localparam int MAG_W   = gist_pkg::MAG_W;
  localparam int SQ_W    = gist_pkg::SQ_W;
  localparam int PEAK_W  = gist_pkg::PEAK_W;
  localparam int MS_W    = gist_pkg::MS_CFG_W;

  // --------------------------------------------------------------------------
  // Configuration registers. Write them only while the block is idle; the block itself does not enforce this.
  // --------------------------------------------------------------------------
  logic [gist_pkg::THR_W-1:0] motion_thr_r;
  logic [MS_W-1:0]            idle_timeout_r;
  logic [MS_W-1:0]            status_interval_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      motion_thr_r      <= gist_pkg::THR_RST;
      idle_timeout_r    <= gist_pkg::TIMEOUT_RST;
      status_interval_r <= gist_pkg::INTERVAL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gist_pkg::CFG_MOTION_THR:      motion_thr_r      <= cfg_wdata;
        gist_pkg::CFG_IDLE_TIMEOUT:    idle_timeout_r    <= cfg_wdata[MS_W-1:0];
        gist_pkg::CFG_STATUS_INTERVAL: status_interval_r <= cfg_wdata[MS_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline flow control. Each stage moves on when the stage after it is
  // empty or itself moving, so bubbles are squeezed out even while the output
  // register holds a result that has not been transferred yet.
  // --------------------------------------------------------------------------
  logic [NUM_STG-1:0] stg_vld_r;
  logic [NUM_STG-1:0] stg_vld_nxt;
  logic [NUM_STG-1:0] adv;
  logic               in_fire;

  always_comb begin
    adv[NUM_STG-1] = stg_vld_r[NUM_STG-1] & out_ready;
    for (int i = NUM_STG - 2; i >= 0; i--) begin
      adv[i] = stg_vld_r[i] & (~stg_vld_r[i+1] | adv[i+1]);
    end
    in_ready = ~stg_vld_r[0] | adv[0];
    in_fire  = in_valid & in_ready;
    stg_vld_nxt[0] = in_fire | (stg_vld_r[0] & ~adv[0]);
    for (int i = 1; i < NUM_STG; i++) begin
      stg_vld_nxt[i] = adv[i-1] | (stg_vld_r[i] & ~adv[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= '0;
    end else begin
      stg_vld_r <= stg_vld_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: input register.
  // --------------------------------------------------------------------------
  logic signed [gist_pkg::WHOLE_W-1:0] s0_whole_r [3];
  logic signed [gist_pkg::MICRO_W-1:0] s0_micro_r [3];
  logic [TIME_WIDTH-1:0]               s0_now_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s0_whole_r[0] <= in_rate_x_whole;
      s0_micro_r[0] <= in_rate_x_micro;
      s0_whole_r[1] <= in_rate_y_whole;
      s0_micro_r[1] <= in_rate_y_micro;
      s0_whole_r[2] <= in_rate_z_whole;
      s0_micro_r[2] <= in_rate_z_micro;
      s0_now_r      <= in_now_ms;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: per-axis magnitudes and the L1 rate in mrad/s. The micro-rad/s
  // sum is divided by one thousand through a reciprocal multiplication.
  // --------------------------------------------------------------------------
  logic [MAG_W-1:0]            axis_mag  [3];
  logic [gist_pkg::WHOLE_W-1:0] whole_mag [3];
  logic [gist_pkg::MICRO_W-1:0] micro_mag [3];

  for (genvar a = 0; a < 3; a++) begin : g_axis
    gist_axis_mag u_axis_mag (
      .whole     (s0_whole_r[a]),
      .micro     (s0_micro_r[a]),
      .rate_mag  (axis_mag[a]),
      .whole_mag (whole_mag[a]),
      .micro_mag (micro_mag[a])
    );
  end

  logic [7:0]                  wsum;
  logic [gist_pkg::MSUM_W-1:0] msum;
  logic [44:0]                 msum_prod;
  logic [PEAK_W-1:0]           l1_rate;

  always_comb begin
    wsum      = 8'(whole_mag[0]) + 8'(whole_mag[1]) + 8'(whole_mag[2]);
    msum      = gist_pkg::MSUM_W'(micro_mag[0]) + gist_pkg::MSUM_W'(micro_mag[1])
              + gist_pkg::MSUM_W'(micro_mag[2]);
    msum_prod = 45'(msum) * 45'(gist_pkg::RECIP_MS);
    l1_rate   = PEAK_W'(wsum) * PEAK_W'(1000)
              + PEAK_W'(msum_prod[44:gist_pkg::RECIP_MS_SH]);
  end

  logic [MAG_W-1:0]      s1_mag_r [3];
  logic [PEAK_W-1:0]     s1_l1_r;
  logic [TIME_WIDTH-1:0] s1_now_r;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_mag_r <= axis_mag;
      s1_l1_r  <= l1_rate;
      s1_now_r <= s0_now_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: one square per axis.
  // --------------------------------------------------------------------------
  logic [SQ_W-1:0]       s2_sq_r [3];
  logic [PEAK_W-1:0]     s2_l1_r;
  logic [TIME_WIDTH-1:0] s2_now_r;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      for (int a = 0; a < 3; a++) begin
        s2_sq_r[a] <= SQ_W'(s1_mag_r[a]) * SQ_W'(s1_mag_r[a]);
      end
      s2_l1_r  <= s1_l1_r;
      s2_now_r <= s1_now_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: sum of squares against the squared threshold. The sum cannot
  // overflow 54 bits.
  // --------------------------------------------------------------------------
  logic [gist_pkg::SUMSQ_W-1:0] sumsq;

  assign sumsq = gist_pkg::SUMSQ_W'(s2_sq_r[0]) + gist_pkg::SUMSQ_W'(s2_sq_r[1])
               + gist_pkg::SUMSQ_W'(s2_sq_r[2]);

  logic                  s3_motion_r;
  logic [PEAK_W-1:0]     s3_l1_r;
  logic [TIME_WIDTH-1:0] s3_now_r;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s3_motion_r <= sumsq > motion_thr_r;
      s3_l1_r     <= s2_l1_r;
      s3_now_r    <= s2_now_r;
    end
  end

  // --------------------------------------------------------------------------
  // Timer state. It is read and updated by the item leaving stage 3, so each
  // sample sees exactly what its predecessor left behind. Time differences
  // wrap modulo 2^TIME_WIDTH; a motion sample has an idle time of zero.
  // --------------------------------------------------------------------------
  logic [TIME_WIDTH-1:0] last_motion_r;
  logic [TIME_WIDTH-1:0] last_report_r;
  logic [PEAK_W-1:0]     peak_r;

  logic [TIME_WIDTH-1:0] idle_ms;
  logic [TIME_WIDTH-1:0] since_report;
  logic                  report;
  logic                  sleep_req;
  logic                  idle_sat;
  logic [PEAK_W-1:0]     peak_cur;

  always_comb begin
    idle_ms      = s3_motion_r ? '0 : s3_now_r - last_motion_r;
    since_report = s3_now_r - last_report_r;
    report       = since_report >= TIME_WIDTH'(status_interval_r);
    sleep_req    = idle_ms >= TIME_WIDTH'(idle_timeout_r);
    idle_sat     = idle_ms >= TIME_WIDTH'(gist_pkg::IDLE_SAT_MS);
    peak_cur     = (s3_l1_r > peak_r) ? s3_l1_r : peak_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_motion_r <= '0;
      last_report_r <= '0;
      peak_r        <= '0;
    end else if (adv[3]) begin
      if (s3_motion_r) begin
        last_motion_r <= s3_now_r;
      end
      if (report) begin
        last_report_r <= s3_now_r;
      end
      // The report carries the peak; the next interval starts from zero.
      peak_r <= report ? '0 : peak_cur;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: flags, the peak and the idle time below the saturation point.
  // --------------------------------------------------------------------------
  logic              s4_sleep_r;
  logic              s4_report_r;
  logic              s4_sat_r;
  logic [MS_W-1:0]   s4_idle_lo_r;
  logic [PEAK_W-1:0] s4_peak_r;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s4_sleep_r   <= sleep_req;
      s4_report_r  <= report;
      s4_sat_r     <= idle_sat;
      s4_idle_lo_r <= idle_ms[MS_W-1:0];
      s4_peak_r    <= peak_cur;
    end
  end

  // --------------------------------------------------------------------------
  // Seconds of idle time: milliseconds divided by one thousand through a
  // reciprocal multiplication, exact below the saturation point. The field
  // is zero when no report is due.
  // --------------------------------------------------------------------------
  logic [52:0]                 secs_prod;
  logic [gist_pkg::SECS_W-1:0] idle_secs;

  always_comb begin
    secs_prod = 53'(s4_idle_lo_r) * 53'(gist_pkg::RECIP_S);
    if (!s4_report_r) begin
      idle_secs = '0;
    end else if (s4_sat_r) begin
      idle_secs = gist_pkg::IDLE_SAT_S;
    end else begin
      idle_secs = secs_prod[gist_pkg::RECIP_S_SH +: gist_pkg::SECS_W];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: result register.
  // --------------------------------------------------------------------------
  logic                        out_sleep_r;
  logic                        out_status_r;
  logic [gist_pkg::SECS_W-1:0] out_secs_r;
  logic [PEAK_W-1:0]           out_peak_r;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      out_sleep_r  <= s4_sleep_r;
      out_status_r <= s4_report_r;
      out_secs_r   <= idle_secs;
      out_peak_r   <= s4_peak_r;
    end
  end

  assign out_valid          = stg_vld_r[NUM_STG-1];
  assign out_sleep_request  = out_sleep_r;
  assign out_status_valid   = out_status_r;
  assign out_idle_seconds   = out_secs_r;
  assign out_peak_rate_mrad = out_peak_r;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  a_secs_zero_without_status: assert property (
    @(posedge clk) disable iff (!rst_n)
    out_valid && !out_status_valid |-> out_idle_seconds == '0)
    else $error("idle seconds reported without a status report");

  a_peak_cleared_on_report: assert property (
    @(posedge clk) disable iff (!rst_n)
    adv[3] && report |=> peak_r == '0)
    else $error("peak not cleared after a status report");

  a_motion_time_taken: assert property (
    @(posedge clk) disable iff (!rst_n)
    adv[3] && s3_motion_r |=> last_motion_r == $past(s3_now_r))
    else $error("motion sample did not update the last motion time");

  a_empty_front_accepts: assert property (
    @(posedge clk) disable iff (!rst_n)
    !stg_vld_r[0] |-> in_ready)
    else $error("empty input stage refused a transfer");

endmodule
`default_nettype wire
